FILE: src/streaming_pattern_match_finder_unit_assert.svh
// assertion macros for the streaming pattern match finder unit
// used by the files that check their own logic; no other dependencies
`ifndef STREAMING_PATTERN_MATCH_FINDER_UNIT_ASSERT_SVH
`define STREAMING_PATTERN_MATCH_FINDER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SPMF_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPMF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/spmf_pkg.sv
// shared types, constants and helpers of the streaming pattern match finder
// no dependencies
package spmf_pkg;

  localparam int PAT_BYTES  = 16;  // pattern bytes held in the two pattern registers
  localparam int PAT_IDX_W  = 4;   // index into the pattern bytes
  localparam int LEN_W      = 5;   // pattern length register width
  localparam int START_W    = 32;  // start offset register width
  localparam int POS_OUT_W  = 32;  // reported position width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [7:0] byte_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO     = 3'd0,
    REG_PAT_HI     = 3'd1,
    REG_PAT_LEN    = 3'd2,
    REG_START      = 3'd3,
    REG_FIRST_ONLY = 3'd4
  } spmf_reg_t;

  // configuration as seen by the datapath (length already clamped)
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [LEN_W-1:0]      pat_len;
    logic [START_W-1:0]    start_offset;
    logic                  first_only;
  } spmf_cfg_t;

  // one text byte moving from the input stage into the datapath
  typedef struct packed {
    logic  valid;
    byte_t text_byte;
    logic  is_final;
  } spmf_step_t;

  // decision for one text byte
  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] pos;
    logic                 done;
  } spmf_result_t;

  // pattern byte k, byte 0 in bits 7:0 of the low word
  function automatic byte_t pat_byte(input logic [CFG_DATA_W-1:0] lo,
                                     input logic [CFG_DATA_W-1:0] hi,
                                     input logic [PAT_IDX_W-1:0]  idx);
    logic [2*CFG_DATA_W-1:0] w;
    w = {hi, lo};
    return w[{idx, 3'b000} +: 8];
  endfunction

endpackage

FILE: src/spmf_if.sv
// valid/ready channel interfaces of the streaming pattern match finder
// depends on spmf_pkg
interface spmf_in_if import spmf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  is_final;

  modport source (output valid, text_byte, is_final, input ready);
  modport sink   (input valid, text_byte, is_final, output ready);
endinterface

interface spmf_out_if import spmf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 match_found;
  logic [POS_OUT_W-1:0] match_position;
  logic                 search_done;

  modport source (output valid, match_found, match_position, search_done, input ready);
  modport sink   (input valid, match_found, match_position, search_done, output ready);
endinterface

interface spmf_cfg_if import spmf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/spmf_window.sv
// byte window shift register and parallel compare against the pattern
// depends on spmf_pkg
module spmf_window import spmf_pkg::*; #(
  parameter int PAT_MAX = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  spmf_step_t step,
  input  spmf_cfg_t  cfg,
  output logic       window_eq
);

  byte_t win_r   [PAT_MAX];
  byte_t win_nxt [PAT_MAX];
  logic [PAT_MAX-1:0] lane_ok;

  // window after the new byte shifts in, newest byte in lane 0
  for (genvar j = 0; j < PAT_MAX; j++) begin : g_lane
    logic [LEN_W-1:0] pidx;

    if (j == 0) begin : g_head
      assign win_nxt[j] = step.text_byte;
    end else begin : g_tail
      assign win_nxt[j] = win_r[j-1];
    end

    // lane j holds the byte that lines up with pattern byte len-1-j
    assign pidx = cfg.pat_len - LEN_W'(1) - LEN_W'(j);
    assign lane_ok[j] = (LEN_W'(j) >= cfg.pat_len) ||
                        (win_nxt[j] == pat_byte(cfg.pat_lo, cfg.pat_hi,
                                                pidx[PAT_IDX_W-1:0]));
  end

  assign window_eq = &lane_ok;

  // shift on every byte, clear at end of text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < PAT_MAX; j++) win_r[j] <= '0;
    end else if (step.valid) begin
      for (int j = 0; j < PAT_MAX; j++) win_r[j] <= step.is_final ? '0 : win_nxt[j];
    end
  end

endmodule

FILE: src/spmf_tracker.sv
// position counter, non-overlap bound and first-match bookkeeping
// depends on spmf_pkg and the assertion macro header
`include "streaming_pattern_match_finder_unit_assert.svh"
module spmf_tracker import spmf_pkg::*; #(
  parameter int POS_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  spmf_step_t   step,
  input  spmf_cfg_t    cfg,
  input  logic         window_eq,
  output spmf_result_t res
);

  localparam logic [POS_BITS-1:0] PosMax = '1;

  logic [POS_BITS-1:0]         cnt_r, cnt_nxt;
  logic [POS_BITS-1:0]         ens_r, ens_nxt;
  logic                        first_r, first_nxt;
  logic [POS_BITS+START_W-1:0] start_ext;
  logic [POS_BITS-1:0]         start;
  logic [POS_BITS-1:0]         m;
  logic [POS_BITS-1:0]         cnt_inc;
  logic [POS_BITS-1:0]         s;
  logic [POS_BITS-1:0]         lo;
  logic [POS_BITS:0]           end_sum;
  logic                        found;
  logic [POS_BITS-1:0]         pos;
  logic [POS_BITS+POS_OUT_W-1:0] pos_ext;

  // match decision and next state for one byte
  always_comb begin
    start_ext = {{POS_BITS{1'b0}}, cfg.start_offset};
    start     = start_ext[POS_BITS-1:0];
    m         = POS_BITS'(cfg.pat_len);
    cnt_inc   = (cnt_r == PosMax) ? cnt_r : cnt_r + 1'b1;
    s         = cnt_inc - m;
    lo        = (start > ens_r) ? start : ens_r;
    end_sum   = {1'b0, s} + {1'b0, m};

    found     = 1'b0;
    pos       = '0;
    cnt_nxt   = cnt_inc;
    ens_nxt   = ens_r;
    first_nxt = first_r;

    if (cfg.pat_len == '0) begin
      // empty pattern reports the start offset once in first-only mode
      if (cfg.first_only && !first_r && cnt_inc >= start) begin
        found     = 1'b1;
        pos       = start;
        first_nxt = 1'b1;
      end
    end else if (!(cfg.first_only && first_r) && cnt_inc >= m && s >= lo && window_eq) begin
      found     = 1'b1;
      pos       = s;
      first_nxt = 1'b1;
      ens_nxt   = end_sum[POS_BITS] ? PosMax : end_sum[POS_BITS-1:0];
    end

    // end of text returns to the reset state
    if (step.is_final) begin
      cnt_nxt   = '0;
      ens_nxt   = '0;
      first_nxt = 1'b0;
    end

    pos_ext   = {{POS_OUT_W{1'b0}}, pos};
    res.found = found;
    res.pos   = pos_ext[POS_OUT_W-1:0];
    res.done  = step.is_final;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ens_r   <= '0;
      first_r <= 1'b0;
    end else if (step.valid) begin
      cnt_r   <= cnt_nxt;
      ens_r   <= ens_nxt;
      first_r <= first_nxt;
    end
  end

  `SPMF_ASSERT_NEXT(a_final_clears, clk, rst_n, step.valid && step.is_final, cnt_r == '0 && ens_r == '0 && !first_r, "text state not cleared after final byte")
  `SPMF_ASSERT_IMPL(a_first_only_once, clk, rst_n, step.valid && cfg.first_only && first_r, !res.found, "second match in first-only mode")
  `SPMF_ASSERT_NEXT(a_bound_monotonic, clk, rst_n, step.valid && !step.is_final, ens_r >= $past(ens_r), "next-start bound moved backward")

endmodule

FILE: src/streaming_pattern_match_finder_unit.sv
// A byte's result goes from its input transfer through the input register, then the window compare
// and position logic, into the result register that drives the output.
// Throughput: one text byte per cycle; a byte with no match that is not final leaves no result.
// The input stage stalls only while a result waits in the output register.
// Reset (rst_n low, synchronous): configuration, window, counters and both stages clear.
// top level: configuration registers, input stage, datapath, result register
// depends on spmf_pkg, spmf_if, spmf_window, spmf_tracker and the assertion macro header
`include "streaming_pattern_match_finder_unit_assert.svh"
module streaming_pattern_match_finder_unit import spmf_pkg::*; #(
  parameter int PAT_MAX  = 16,
  parameter int POS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  spmf_in_if.sink     in_bus,
  spmf_out_if.source  out_bus,
  spmf_cfg_if.sink    cfg_bus
);

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic [START_W-1:0]    start_r;
  logic                  first_only_r;
  spmf_cfg_t             cfg;

  // input stage
  logic  a_valid_r, a_valid_nxt;
  byte_t a_byte_r;
  logic  a_final_r;
  logic  adv;
  spmf_step_t step;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 found_r;
  logic [POS_OUT_W-1:0] pos_r;
  logic                 done_r;

  logic         window_eq;
  spmf_result_t res;

  // configuration write channel, always ready
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r     <= '0;
      pat_hi_r     <= '0;
      pat_len_r    <= '0;
      start_r      <= '0;
      first_only_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      unique case (spmf_reg_t'(cfg_bus.index))
        REG_PAT_LO:     pat_lo_r     <= cfg_bus.data;
        REG_PAT_HI:     pat_hi_r     <= cfg_bus.data;
        REG_PAT_LEN:    pat_len_r    <= cfg_bus.data[LEN_W-1:0];
        REG_START:      start_r      <= cfg_bus.data[START_W-1:0];
        REG_FIRST_ONLY: first_only_r <= cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  // lengths above the window depth act as the window depth
  always_comb begin
    cfg.pat_lo       = pat_lo_r;
    cfg.pat_hi       = pat_hi_r;
    cfg.pat_len      = (pat_len_r > LEN_W'(PAT_MAX)) ? LEN_W'(PAT_MAX) : pat_len_r;
    cfg.start_offset = start_r;
    cfg.first_only   = first_only_r;
  end

  // input stage advances whenever the result register can take its outcome
  assign adv          = a_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !a_valid_r || adv;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_bus.valid && in_bus.ready) a_valid_nxt = 1'b1;
    else if (adv)                     a_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      a_byte_r  <= in_bus.text_byte;
      a_final_r <= in_bus.is_final;
    end
  end

  assign step.valid     = adv;
  assign step.text_byte = a_byte_r;
  assign step.is_final  = a_final_r;

  spmf_window #(
    .PAT_MAX (PAT_MAX)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg       (cfg),
    .window_eq (window_eq)
  );

  spmf_tracker #(
    .POS_BITS (POS_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg       (cfg),
    .window_eq (window_eq),
    .res       (res)
  );

  // result register: loads on a match or the final byte
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv)                out_valid_nxt = res.found || res.done;
    else if (out_bus.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found_r <= res.found;
      pos_r   <= res.pos;
      done_r  <= res.done;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.match_found    = found_r;
  assign out_bus.match_position = pos_r;
  assign out_bus.search_done    = done_r;

  `SPMF_ASSERT_IMPL(a_result_has_cause, clk, rst_n, out_valid_r, found_r || done_r, "result with neither match nor done")
  `SPMF_ASSERT_IMPL(a_nomatch_pos_zero, clk, rst_n, out_valid_r && !found_r, pos_r == '0, "position set without a match")
  `SPMF_ASSERT_IMPL(a_result_from_step, clk, rst_n, $rose(out_valid_r), $past(adv), "result appeared without a byte step")

endmodule

FILE: sim/streaming_pattern_match_finder_unit_test.sv
// self-checking testbench for the streaming pattern match finder unit
// drives text bytes and register writes, predicts every result and compares each transfer
// depends on spmf_pkg, spmf_if and streaming_pattern_match_finder_unit
module streaming_pattern_match_finder_unit_test import spmf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1060;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 4;

  typedef enum int {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    spmf_reg_t            idx;
    logic [CFG_DATA_W-1:0] data;
    byte_t                text_byte;
    logic                 is_final;
    bit                   typed;
    bit                   want_has;
    spmf_result_t         want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  spmf_in_if  in_bus ();
  spmf_out_if out_bus ();
  spmf_cfg_if cfg_bus ();

  streaming_pattern_match_finder_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always #5 clk = ~clk;

  // side fields that travel with each input byte: typed-in expectation for table rows
  logic         in_typed;
  logic         in_want_has;
  spmf_result_t in_want;

  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;

  spmf_result_t hits_pending[$];
  plan_row_t    plan[$];

  // predictor copy of the registers
  logic [CFG_DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic [START_W-1:0]    start_r;
  logic                  first_only_r;

  // predictor copy of the per-text state
  byte_t       text_win[16];
  logic [31:0] text_pos;
  logic [31:0] resume_at;
  bit          reported_once;

  function automatic void clear_text_state();
    foreach (text_win[i]) text_win[i] = 8'h00;
    text_pos = '0;
    resume_at = '0;
    reported_once = 1'b0;
  endfunction

  // expected outcome of one accepted text byte; returns 1 when a result is due
  function automatic bit scan_text_byte(input byte_t b, input logic fin,
                                        output spmf_result_t res);
    int unsigned m;
    logic [31:0] s, lo;
    logic [127:0] pat;
    bit eq;
    m = (pat_len_r > 5'd16) ? 16 : int'(pat_len_r);
    pat = {pat_hi_r, pat_lo_r};
    res = '0;
    for (int i = 15; i > 0; i--) text_win[i] = text_win[i-1];
    text_win[0] = b;
    if (text_pos != 32'hFFFF_FFFF) text_pos++;
    if (m == 0) begin
      // empty pattern: start offset once, first-only mode only
      if (first_only_r && !reported_once && text_pos >= start_r) begin
        res.found = 1'b1;
        res.pos = start_r;
        reported_once = 1'b1;
      end
    end else if (!(first_only_r && reported_once) && text_pos >= m) begin
      s = text_pos - m;
      lo = (start_r > resume_at) ? start_r : resume_at;
      if (s >= lo) begin
        eq = 1'b1;
        for (int k = 0; k < m; k++)
          if (pat[k*8 +: 8] != text_win[m-1-k]) eq = 1'b0;
        if (eq) begin
          res.found = 1'b1;
          res.pos = s;
          reported_once = 1'b1;
          resume_at = (32'hFFFF_FFFF - s < m) ? 32'hFFFF_FFFF : s + m;
        end
      end
    end
    res.done = fin;
    if (fin) clear_text_state();
    return res.found || fin;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // prediction on every accepted transfer, comparison on every result transfer
  always @(posedge clk) begin : scoreboard
    spmf_result_t want, got;
    bit has;
    if (!rst_n) begin
      pat_lo_r = '0;
      pat_hi_r = '0;
      pat_len_r = '0;
      start_r = '0;
      first_only_r = 1'b0;
      clear_text_state();
      hits_pending.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (spmf_reg_t'(cfg_bus.index))
          REG_PAT_LO:     pat_lo_r = cfg_bus.data;
          REG_PAT_HI:     pat_hi_r = cfg_bus.data;
          REG_PAT_LEN:    pat_len_r = cfg_bus.data[LEN_W-1:0];
          REG_START:      start_r = cfg_bus.data[START_W-1:0];
          REG_FIRST_ONLY: first_only_r = cfg_bus.data[0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        has = scan_text_byte(in_bus.text_byte, in_bus.is_final, want);
        if (in_typed) begin
          has = in_want_has;
          want = in_want;
        end
        if (has) hits_pending.insert(hits_pending.size(), want);
      end
      if (out_bus.valid && out_bus.ready) begin
        got.found = out_bus.match_found;
        got.pos = out_bus.match_position;
        got.done = out_bus.search_done;
        if (hits_pending.size() == 0) begin
          note_mismatch("result with nothing pending", got.pos, '0);
        end else begin
          want = hits_pending.pop_front();
          if (got.found !== want.found) note_mismatch("match_found", got.found, want.found);
          if (got.pos !== want.pos) note_mismatch("match_position", got.pos, want.pos);
          if (got.done !== want.done) note_mismatch("search_done", got.done, want.done);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(gaps_on && $urandom_range(0, 99) < 20);
      end
    end
  end

  // offer one text byte, return at the falling edge after its transfer
  task automatic send_item(byte_t b, logic fin, bit typed, bit want_has, spmf_result_t want);
    while (gaps_on && $urandom_range(0, 99) < 20) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.text_byte <= b;
    in_bus.is_final <= fin;
    in_typed <= typed;
    in_want_has <= want_has;
    in_want <= want;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // one register write; valid stays high for the caller to lower
  task automatic put_reg(spmf_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  task automatic load_regs(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                           logic [31:0] start, logic fo);
    put_reg(REG_PAT_LO, lo);
    put_reg(REG_PAT_HI, hi);
    put_reg(REG_PAT_LEN, {59'd0, len});
    put_reg(REG_START, {32'd0, start});
    put_reg(REG_FIRST_ONLY, {63'd0, fo});
    cfg_bus.valid <= 1'b0;
  endtask

  // sender stops until every pending result has come back
  task automatic drain_pause();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (hits_pending.size() != 0) @(negedge clk);
  endtask

  // idle block: drained plus the pipeline depth for bytes that leave no result
  task automatic quiesce();
    drain_pause();
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic void add_write(spmf_reg_t idx, logic [CFG_DATA_W-1:0] value);
    plan_row_t row;
    row = '{kind: ROW_WRITE, idx: REG_PAT_LO, default: '0};
    row.idx = idx;
    row.data = value;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_byte(byte_t b, logic fin, bit typed, bit has,
                                   logic found, logic [31:0] pos);
    plan_row_t row;
    row = '{kind: ROW_BYTE, idx: REG_PAT_LO, default: '0};
    row.text_byte = b;
    row.is_final = fin;
    row.typed = typed;
    row.want_has = has;
    row.want.found = found;
    row.want.pos = pos;
    row.want.done = fin;
    plan.insert(plan.size(), row);
  endfunction

  initial begin : stimulus
    byte_t alpha[4];
    byte_t pat[16];
    byte_t text[$];
    logic [63:0] lo, hi;
    logic [31:0] start;
    logic fo;
    int len, m, r, tlen, n_texts, pause_at, phase, sent;
    bit open_end;

    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.text_byte <= '0;
    in_bus.is_final <= 1'b0;
    in_typed <= 1'b0;
    in_want_has <= 1'b0;
    in_want <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_PAT_LO;
    cfg_bus.data <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: reset values, empty pattern, start offset extremes,
    // non-overlap, pattern longer than text, oversized length
    add_byte(8'h00, 1'b1, 1, 1, 1'b0, 32'd0);
    add_write(REG_FIRST_ONLY, 64'd1);
    add_byte(8'hFF, 1'b0, 1, 1, 1'b1, 32'd0);
    add_byte(8'h55, 1'b1, 1, 1, 1'b0, 32'd0);
    add_write(REG_START, 64'd2);
    add_byte(8'h01, 1'b0, 1, 0, 1'b0, 32'd0);
    add_byte(8'h02, 1'b0, 1, 1, 1'b1, 32'd2);
    add_byte(8'h03, 1'b1, 1, 1, 1'b0, 32'd0);
    add_write(REG_START, 64'hFFFF_FFFF);
    add_byte(8'hAA, 1'b1, 1, 1, 1'b0, 32'd0);
    add_write(REG_START, 64'd0);
    add_write(REG_FIRST_ONLY, 64'd0);
    add_write(REG_PAT_LO, 64'h4241);
    add_write(REG_PAT_LEN, 64'd2);
    add_byte(8'h41, 1'b0, 0, 0, 1'b0, 32'd0);
    add_byte(8'h42, 1'b0, 0, 0, 1'b0, 32'd0);
    add_byte(8'h41, 1'b0, 0, 0, 1'b0, 32'd0);
    add_byte(8'h42, 1'b0, 0, 0, 1'b0, 32'd0);
    add_byte(8'h80, 1'b1, 1, 1, 1'b0, 32'd0);
    add_write(REG_PAT_LO, 64'h4141);
    add_byte(8'h41, 1'b0, 1, 0, 1'b0, 32'd0);
    add_byte(8'h41, 1'b0, 1, 1, 1'b1, 32'd0);
    add_byte(8'h41, 1'b0, 1, 0, 1'b0, 32'd0);
    add_byte(8'h41, 1'b1, 1, 1, 1'b1, 32'd2);
    add_write(REG_PAT_LEN, 64'd3);
    add_byte(8'h41, 1'b0, 1, 0, 1'b0, 32'd0);
    add_byte(8'h41, 1'b1, 1, 1, 1'b0, 32'd0);
    add_write(REG_PAT_LO, '1);
    add_write(REG_PAT_HI, '1);
    add_write(REG_PAT_LEN, 64'd31);
    add_byte(8'hFF, 1'b1, 1, 1, 1'b0, 32'd0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        quiesce();
        put_reg(plan[i].idx, plan[i].data);
        cfg_bus.valid <= 1'b0;
      end else begin
        send_item(plan[i].text_byte, plan[i].is_final, plan[i].typed,
                  plan[i].want_has, plan[i].want);
      end
    end

    // back pressure: a stream of one-byte matches against a long receiver hold
    quiesce();
    load_regs(64'h5A, 64'h0, 5'd1, 32'd0, 1'b0);
    hold_req = 1'b1;
    for (int j = 0; j < 60; j++) send_item(8'h5A, j == 59, 0, 0, '0);

    // random phases: fresh registers, then texts seeded with pattern copies
    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiesce();
      gaps_on = !(phase >= 6 && phase < 12);
      for (int i = 0; i < 4; i++) alpha[i] = $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0) begin
        alpha[0] = 8'h00;
        alpha[1] = 8'hFF;
      end
      r = $urandom_range(0, 99);
      if (r < 8) len = 0;
      else if (r < 70) len = $urandom_range(1, 4);
      else if (r < 90) len = $urandom_range(5, 16);
      else len = $urandom_range(17, 31);
      m = (len > 16) ? 16 : len;
      r = $urandom_range(0, 99);
      for (int k = 0; k < 16; k++) begin
        if (r < 10) pat[k] = $urandom_range(0, 255);
        else if (r < 15) pat[k] = 8'hFF;
        else pat[k] = alpha[$urandom_range(0, 3)];
      end
      for (int k = 0; k < 8; k++) begin
        lo[k*8 +: 8] = pat[k];
        hi[k*8 +: 8] = pat[k+8];
      end
      r = $urandom_range(0, 99);
      if (r < 55) start = 32'd0;
      else if (r < 85) start = $urandom_range(0, 30);
      else if (r < 93) start = 32'hFFFF_FFFF;
      else start = $urandom;
      fo = ($urandom_range(0, 99) < 35);
      load_regs(lo, hi, len[4:0], start, fo);

      n_texts = $urandom_range(1, 3);
      for (int t = 0; t < n_texts; t++) begin
        tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        text.delete();
        while (text.size() < tlen) begin
          if (m > 0 && $urandom_range(0, 99) < 25) begin
            for (int k = 0; k < m; k++) text.insert(text.size(), pat[k]);
            // occasionally break the copy by one bit
            if ($urandom_range(0, 9) == 0)
              text[text.size() - 1 - $urandom_range(0, m - 1)] ^= 8'h01 << $urandom_range(0, 7);
          end else if ($urandom_range(0, 99) < 80) begin
            text.insert(text.size(), alpha[$urandom_range(0, 3)]);
          end else begin
            text.insert(text.size(), byte_t'($urandom_range(0, 255)));
          end
        end
        // a text left open carries into the next register setting
        open_end = (t == n_texts - 1) && ($urandom_range(0, 99) < 15);
        pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, text.size() - 1) : -1;
        foreach (text[j]) begin
          if (j == pause_at) drain_pause();
          send_item(text[j], (j == text.size() - 1) && !open_end, 0, 0, '0);
          sent++;
        end
      end
      phase++;
    end

    // wind down
    drain_pause();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
